@@ src/pcma_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Per-channel moving average package
// Shared widths, parameter defaults and the control state type.
// ----------------------------------------------------------------------------
package pcma_pkg;

  // Fixed field widths of the sample and result words.
  localparam int TAG_W    = 4;
  localparam int SAMPLE_W = 12;
  localparam int FILT_W   = 13;

  // Largest value the filtered output can carry; larger results saturate.
  localparam logic [FILT_W-1:0] VALUE_MAX = {FILT_W{1'b1}};

  // Defaults for the top-level parameters.
  localparam int CHANNELS_DEF    = 16;
  localparam int WINDOW_BITS_DEF = 4;
  localparam int EXTRA_BITS_DEF  = 1;
  localparam int SAMPLE_BITS_DEF = 12;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_DIVIDE,
    ST_FINISH
  } state_t;

endpackage

@@ src/pcma_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Per-channel moving average channel interfaces
// Valid/ready channels for samples, results and the setup register.
// ----------------------------------------------------------------------------
interface pcma_sample_if;
  logic                          valid;
  logic                          ready;
  logic [pcma_pkg::TAG_W-1:0]    channel_tag;
  logic [pcma_pkg::SAMPLE_W-1:0] sample_value;

  modport source (output valid, channel_tag, sample_value, input ready);
  modport sink   (input valid, channel_tag, sample_value, output ready);
endinterface

interface pcma_result_if;
  logic                        valid;
  logic                        ready;
  logic [pcma_pkg::TAG_W-1:0]  out_channel;
  logic [pcma_pkg::FILT_W-1:0] filtered_value;
  logic                        window_full;

  modport source (output valid, out_channel, filtered_value, window_full, input ready);
  modport sink   (input valid, out_channel, filtered_value, window_full, output ready);
endinterface

interface pcma_setup_if;
  logic valid;
  logic ready;
  logic high_res_mode;

  modport source (output valid, high_res_mode, input ready);
  modport sink   (input valid, high_res_mode, output ready);
endinterface

@@ src/pcma_divider.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bit-serial restoring divider
// Produces one quotient bit per cycle; done pulses when the quotient is final.
// ----------------------------------------------------------------------------
module pcma_divider #(
  parameter int NUM_W = 16,
  parameter int DEN_W = 5
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] dividend,
  input  logic [DEN_W-1:0] divisor,
  output logic             done,
  output logic [NUM_W-1:0] quotient
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] quo;
  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] dsr;
  logic [CNT_W-1:0] count;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             ge;

  // The dividend shifts out of the top of quo while quotient bits enter below.
  assign trial = {rem, quo[NUM_W-1]};
  assign diff  = trial - {1'b0, dsr};
  assign ge    = trial >= {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        count <= CNT_W'(NUM_W);
      end else if (count != '0) begin
        count <= count - CNT_W'(1);
        done  <= (count == CNT_W'(1));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dsr <= divisor;
    end else if (count != '0) begin
      quo <= {quo[NUM_W-2:0], ge};
      rem <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
    end
  end

  assign quotient = quo;

endmodule

@@ src/pcma_history.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sample history memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module pcma_history #(
  parameter int DEPTH  = 256,
  parameter int ADDR_W = 8,
  parameter int DATA_W = 12
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ src/per_channel_moving_average_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Per-channel moving average
// Flow: an accepted sample goes through the update state, then, while the
// channel window is still filling, the divide state, where the bit-serial
// divider gives one quotient bit a cycle, and then the finish state, which
// moves the result into the output register once that register is free.
// A new sample is accepted only after the last result is in the output register.
// Reset (rst, synchronous) empties every channel at once; no clearing pass.
// ----------------------------------------------------------------------------
module per_channel_moving_average_top #(
  parameter int CHANNELS    = pcma_pkg::CHANNELS_DEF,
  parameter int WINDOW_BITS = pcma_pkg::WINDOW_BITS_DEF,
  parameter int EXTRA_BITS  = pcma_pkg::EXTRA_BITS_DEF,
  parameter int SAMPLE_BITS = pcma_pkg::SAMPLE_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  pcma_sample_if.sink    sample,
  pcma_result_if.source  result,
  pcma_setup_if.sink     setup
);

  // Only the low SAMPLE_BITS of the 12-bit sample field take part.
  localparam int SMP_W    = (SAMPLE_BITS < pcma_pkg::SAMPLE_W) ? SAMPLE_BITS
                                                               : pcma_pkg::SAMPLE_W;
  localparam int WIN_LEN  = 1 << WINDOW_BITS;
  localparam int SUM_W    = SMP_W + WINDOW_BITS;
  localparam int FILL_W   = WINDOW_BITS + 1;
  localparam int CH_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int DEPTH    = CHANNELS * WIN_LEN;
  localparam int ADDR_W   = $clog2(DEPTH);
  localparam int HR_SHIFT = (WINDOW_BITS > EXTRA_BITS) ? WINDOW_BITS - EXTRA_BITS : 0;
  localparam int EXT_W    = (SUM_W > pcma_pkg::FILT_W) ? SUM_W : pcma_pkg::FILT_W;

  pcma_pkg::state_t state;
  pcma_pkg::state_t state_next;

  // Setup register. Writes must only arrive while the block is idle; the block does not enforce this.
  logic high_res;

  // Per-channel bookkeeping, small enough to live in flip-flops so reset
  // empties every channel at once.
  logic [SUM_W-1:0]       sum_reg  [CHANNELS];
  logic [WINDOW_BITS-1:0] slot_reg [CHANNELS];
  logic [FILL_W-1:0]      fill_reg [CHANNELS];

  // The sample being processed.
  logic [CH_W-1:0]  cur_ch;
  logic [SMP_W-1:0] cur_smp;

  // Finished result waiting to be moved into the output register.
  logic [pcma_pkg::FILT_W-1:0] res_value;
  logic                        res_full;

  // Output register.
  logic                        out_valid;
  logic [pcma_pkg::TAG_W-1:0]  out_ch;
  logic [pcma_pkg::FILT_W-1:0] out_value;
  logic                        out_full;

  logic                   accept;
  logic                   tag_ok;
  logic [CH_W-1:0]        tag_ch;
  logic [ADDR_W-1:0]      rd_addr;
  logic [ADDR_W-1:0]      wr_addr;
  logic [SMP_W-1:0]       hist_rd;
  logic                   hist_wr;
  logic                   was_full;
  logic [SMP_W-1:0]       old_smp;
  logic [SUM_W-1:0]       new_sum;
  logic [FILL_W-1:0]      fill_inc;
  logic [SUM_W-1:0]       shifted;
  logic                   div_start;
  logic                   div_done;
  logic [SUM_W-1:0]       div_quot;
  logic [SUM_W-1:0]       sat_in;
  logic [EXT_W-1:0]       sat_ext;
  logic [pcma_pkg::FILT_W-1:0] sat_value;
  logic                   load;

  // ---------------------------------------------------------------------------
  // Input side. A sample is taken only when the engine is idle. A word whose
  // tag names a channel that does not exist is consumed and then dropped
  // without touching any channel state and without a result.
  // ---------------------------------------------------------------------------
  assign sample.ready = (state == pcma_pkg::ST_IDLE);
  assign accept       = sample.valid && sample.ready;
  assign tag_ok       = {1'b0, sample.channel_tag} < (pcma_pkg::TAG_W + 1)'(CHANNELS);
  assign tag_ch       = CH_W'(sample.channel_tag);

  // The history is one memory of CHANNELS rows, each a circular window.
  // The entry read at accept is the slot about to be overwritten.
  assign rd_addr = ADDR_W'({tag_ch, slot_reg[tag_ch]});
  assign wr_addr = ADDR_W'({cur_ch, slot_reg[cur_ch]});
  assign hist_wr = (state == pcma_pkg::ST_UPDATE);

  pcma_history #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W),
    .DATA_W (SMP_W)
  ) u_history (
    .clk     (clk),
    .wr_en   (hist_wr),
    .wr_addr (wr_addr),
    .wr_data (cur_smp),
    .rd_en   (accept),
    .rd_addr (rd_addr),
    .rd_data (hist_rd)
  );

  // ---------------------------------------------------------------------------
  // Running-sum update. Slots are written in order from zero, so an entry has
  // been written before only when the window is already full; otherwise the
  // departing sample counts as zero, which stands in for the reset contents.
  // ---------------------------------------------------------------------------
  assign was_full = (fill_reg[cur_ch] == FILL_W'(WIN_LEN));
  assign old_smp  = was_full ? hist_rd : '0;
  assign new_sum  = SUM_W'(({1'b0, sum_reg[cur_ch]} + (SUM_W + 1)'(cur_smp))
                           - (SUM_W + 1)'(old_smp));
  assign fill_inc = fill_reg[cur_ch] + FILL_W'(1);

  // Full window: a plain shift, wider by EXTRA_BITS in high-resolution mode.
  assign shifted = high_res ? (new_sum >> HR_SHIFT) : (new_sum >> WINDOW_BITS);

  // Filling window: the sum is divided by the new fill count, one bit a cycle.
  assign div_start = (state == pcma_pkg::ST_UPDATE) && !was_full;

  pcma_divider #(
    .NUM_W (SUM_W),
    .DEN_W (FILL_W)
  ) u_divider (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (new_sum),
    .divisor  (fill_inc),
    .done     (div_done),
    .quotient (div_quot)
  );

  // Both paths share one saturating stage that clamps to the output width.
  assign sat_in    = (state == pcma_pkg::ST_UPDATE) ? shifted : div_quot;
  assign sat_ext   = EXT_W'(sat_in);
  assign sat_value = (sat_ext > EXT_W'(pcma_pkg::VALUE_MAX)) ? pcma_pkg::VALUE_MAX
                                                             : pcma_pkg::FILT_W'(sat_ext);

  // The result moves to the output register once that register is free or
  // its word is being taken in the same cycle.
  assign load = (state == pcma_pkg::ST_FINISH) && (!out_valid || result.ready);

  // ---------------------------------------------------------------------------
  // Control sequence: idle, update the channel, divide while filling, then
  // hand the result to the output register.
  // ---------------------------------------------------------------------------
  always_comb begin
    state_next = state;
    case (state)
      pcma_pkg::ST_IDLE: begin
        if (accept && tag_ok) begin
          state_next = pcma_pkg::ST_UPDATE;
        end
      end
      pcma_pkg::ST_UPDATE: begin
        state_next = was_full ? pcma_pkg::ST_FINISH : pcma_pkg::ST_DIVIDE;
      end
      pcma_pkg::ST_DIVIDE: begin
        if (div_done) begin
          state_next = pcma_pkg::ST_FINISH;
        end
      end
      pcma_pkg::ST_FINISH: begin
        if (load) begin
          state_next = pcma_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = pcma_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pcma_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Setup register; the port never stalls.
  assign setup.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      high_res <= 1'b0;
    end else if (setup.valid && setup.ready) begin
      high_res <= setup.high_res_mode;
    end
  end

  // Per-channel state: cleared by reset, updated once per accepted sample with a valid tag.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CHANNELS; i++) begin
        sum_reg[i]  <= '0;
        slot_reg[i] <= '0;
        fill_reg[i] <= '0;
      end
    end else if (state == pcma_pkg::ST_UPDATE) begin
      sum_reg[cur_ch]  <= new_sum;
      slot_reg[cur_ch] <= slot_reg[cur_ch] + WINDOW_BITS'(1);
      if (!was_full) begin
        fill_reg[cur_ch] <= fill_inc;
      end
    end
  end

  // Payload registers of the word in flight.
  always_ff @(posedge clk) begin
    if (accept) begin
      cur_ch  <= tag_ch;
      cur_smp <= sample.sample_value[SMP_W-1:0];
    end
    if (state == pcma_pkg::ST_UPDATE) begin
      res_full <= was_full;
      if (was_full) begin
        res_value <= sat_value;
      end
    end else if ((state == pcma_pkg::ST_DIVIDE) && div_done) begin
      res_value <= sat_value;
    end
  end

  // ---------------------------------------------------------------------------
  // Output register. It holds a finished word while the next sample is taken
  // and processed, so the sink may stall without blocking the input.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_ch    <= pcma_pkg::TAG_W'(cur_ch);
      out_value <= res_value;
      out_full  <= res_full;
    end
  end

  assign result.valid          = out_valid;
  assign result.out_channel    = out_ch;
  assign result.filtered_value = out_value;
  assign result.window_full    = out_full;

endmodule

@@ sim/per_channel_moving_average_top_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Per-channel moving average testbench
// Drives channel-tagged samples through the block and checks every result word
// against a predictor that keeps its own per-channel history, sums and fill
// levels, or against the value in a typed table row. A short stimulus table
// covers extremes and window fill-up. Random phases follow, with the register
// switched between the two modes and random gaps and stalls on both sides.
// ----------------------------------------------------------------------------
module per_channel_moving_average_top_tb;

  // The block runs at its default sizes.
  localparam int CHANNELS    = pcma_pkg::CHANNELS_DEF;
  localparam int WINDOW_BITS = pcma_pkg::WINDOW_BITS_DEF;
  localparam int EXTRA_BITS  = pcma_pkg::EXTRA_BITS_DEF;
  localparam int SAMPLE_BITS = pcma_pkg::SAMPLE_BITS_DEF;

  localparam int WIN_LEN  = 1 << WINDOW_BITS;
  localparam int SUM_W    = SAMPLE_BITS + WINDOW_BITS;
  localparam int HR_SHIFT = (WINDOW_BITS > EXTRA_BITS) ? WINDOW_BITS - EXTRA_BITS : 0;
  localparam logic [pcma_pkg::SAMPLE_W-1:0] SAMPLE_MASK =
    pcma_pkg::SAMPLE_W'((1 << SAMPLE_BITS) - 1);
  localparam logic [pcma_pkg::SAMPLE_W-1:0] SAMPLE_TOP = {pcma_pkg::SAMPLE_W{1'b1}};

  // The drain waits more than twice as long as the slowest word takes.
  localparam int DRAIN_CYCLES     = 2 * (SUM_W + 4) + 8;
  // Longest quiet stretch in a correct run is the receiver hold-off plus one
  // divide and a sender gap, so this leaves a wide margin.
  localparam int SQUEEZE_CYCLES   = 400;
  localparam int STALL_LIMIT      = 4000;
  localparam int RANDOM_PHASES    = 4;
  localparam int RANDOM_PER_PHASE = 420;

  typedef struct packed {
    logic [pcma_pkg::TAG_W-1:0]  chan;
    logic [pcma_pkg::FILT_W-1:0] value;
    logic                        full;
  } avg_word_t;

  typedef enum logic {
    ROW_WORD,
    ROW_SETUP
  } row_kind_t;

  // One row of the directed table. A setup row writes the mode register;
  // a word row sends the same sample reps times. When typed is set, the
  // expected result is taken from the row rather than from the predictor.
  typedef struct {
    row_kind_t                     kind;
    bit                            mode;
    logic [pcma_pkg::TAG_W-1:0]    ch;
    logic [pcma_pkg::SAMPLE_W-1:0] smp;
    int                            reps;
    bit                            typed;
    logic [pcma_pkg::FILT_W-1:0]   exp_val;
    bit                            exp_full;
  } stim_row_t;

  logic clk;
  logic rst;

  pcma_sample_if smp_bus ();
  pcma_result_if res_bus ();
  pcma_setup_if  cfg_bus ();

  per_channel_moving_average_top #(
    .CHANNELS    (CHANNELS),
    .WINDOW_BITS (WINDOW_BITS),
    .EXTRA_BITS  (EXTRA_BITS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) dut (
    .clk    (clk),
    .rst    (rst),
    .sample (smp_bus),
    .result (res_bus),
    .setup  (cfg_bus)
  );

  // Predictor state: a copy of every per-channel store plus the mode bit.
  logic [pcma_pkg::SAMPLE_W-1:0] history [CHANNELS][WIN_LEN];
  logic [SUM_W-1:0]              chan_sum [CHANNELS];
  logic [WINDOW_BITS-1:0]        write_pos [CHANNELS];
  logic [WINDOW_BITS:0]          fill_level [CHANNELS];
  logic                          hi_res;

  avg_word_t expected_averages [$];
  int        mismatches;
  int        idle_cycles;

  // Sender side bookkeeping. The typed fields travel with the word on the
  // bus so that the scoreboard can pick them up at the accepting edge.
  int                          burst_left;
  bit                          word_typed;
  logic [pcma_pkg::FILT_W-1:0] word_exp_val;
  bit                          word_exp_full;

  // Set by the stimulus to ask the receiver for one long hold-off.
  bit squeeze_req;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Folds one sample into its channel and returns the word the block should
  // produce. Returns 0 for a channel the block does not have.
  function automatic bit advance_average(input logic [pcma_pkg::TAG_W-1:0] ch,
                                         input logic [pcma_pkg::SAMPLE_W-1:0] raw,
                                         output avg_word_t word);
    logic [pcma_pkg::SAMPLE_W-1:0] smp;
    logic [WINDOW_BITS-1:0]        slot;
    logic [SUM_W-1:0]              avg;
    word = '0;
    if (ch >= CHANNELS) begin
      return 1'b0;
    end
    smp  = raw & SAMPLE_MASK;
    slot = write_pos[ch];
    // The oldest sample leaves the sum as the new one takes its slot.
    chan_sum[ch]      = chan_sum[ch] - history[ch][slot] + smp;
    history[ch][slot] = smp;
    write_pos[ch]     = slot + 1'b1;
    if (fill_level[ch] < WIN_LEN) begin
      // Still filling, including the sample that completes the window.
      fill_level[ch] = fill_level[ch] + 1'b1;
      avg            = chan_sum[ch] / fill_level[ch];
      word.full      = 1'b0;
    end else begin
      avg       = hi_res ? (chan_sum[ch] >> HR_SHIFT) : (chan_sum[ch] >> WINDOW_BITS);
      word.full = 1'b1;
    end
    word.chan  = ch;
    word.value = (avg > pcma_pkg::VALUE_MAX) ? pcma_pkg::VALUE_MAX
                                             : avg[pcma_pkg::FILT_W-1:0];
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string field, input int got, input int want);
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, field, got, want);
    mismatches++;
  endtask

  // Offers one word. The sender works in bursts; between bursts valid drops
  // for a random gap, which is sometimes zero so that long runs go unbroken.
  task automatic send_word(input logic [pcma_pkg::TAG_W-1:0] ch,
                           input logic [pcma_pkg::SAMPLE_W-1:0] smp,
                           input bit typed, input logic [pcma_pkg::FILT_W-1:0] ev,
                           input bit ef);
    int gap;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
      burst_left = $urandom_range(1, 60);
      if (gap != 0) begin
        smp_bus.valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    smp_bus.valid        = 1'b1;
    smp_bus.channel_tag  = ch;
    smp_bus.sample_value = smp;
    word_typed           = typed;
    word_exp_val         = ev;
    word_exp_full        = ef;
    do @(posedge clk); while (!smp_bus.ready);
    @(negedge clk);
  endtask

  // Writes the mode register once the block has gone idle: every expected
  // word has come back, and the drain time has passed on top of that.
  task automatic write_mode(input bit mode);
    smp_bus.valid = 1'b0;
    while (expected_averages.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    cfg_bus.valid         = 1'b1;
    cfg_bus.high_res_mode = mode;
    do @(posedge clk); while (!cfg_bus.ready);
    @(negedge clk);
    cfg_bus.valid = 1'b0;
  endtask

  // Scoreboard. Results are checked before the sample of the same edge is
  // predicted; a result can never belong to a sample accepted on that edge.
  always @(posedge clk) begin : scoreboard
    avg_word_t want;
    avg_word_t model;
    if (!rst) begin
      if (res_bus.valid && res_bus.ready) begin
        if (expected_averages.size() == 0) begin
          report_mismatch("out_channel of a result with nothing pending",
                          int'(res_bus.out_channel), -1);
        end else begin
          want = expected_averages.pop_front();
          if (res_bus.out_channel !== want.chan)
            report_mismatch("out_channel", int'(res_bus.out_channel), int'(want.chan));
          if (res_bus.filtered_value !== want.value)
            report_mismatch("filtered_value", int'(res_bus.filtered_value),
                            int'(want.value));
          if (res_bus.window_full !== want.full)
            report_mismatch("window_full", int'(res_bus.window_full), int'(want.full));
        end
      end
      if (smp_bus.valid && smp_bus.ready) begin
        if (advance_average(smp_bus.channel_tag, smp_bus.sample_value, model)) begin
          if (word_typed)
            expected_averages.push_back('{smp_bus.channel_tag, word_exp_val, word_exp_full});
          else
            expected_averages.push_back(model);
        end
      end
      if (cfg_bus.valid && cfg_bus.ready) begin
        hi_res = cfg_bus.high_res_mode;
      end
    end
  end

  // Watchdog: any handshake on any channel counts as progress.
  always @(posedge clk) begin
    if (rst || (smp_bus.valid && smp_bus.ready) || (res_bus.valid && res_bus.ready) ||
        (cfg_bus.valid && cfg_bus.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("per_channel_moving_average_top_tb failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Receiver. It runs in segments, each with a stall style of its own:
  // always ready, ready with random odds, or a periodic stall. On request it
  // holds ready low for a long stretch so that the block backs up.
  initial begin : result_sink
    int seg_left;
    int style;
    int odds;
    int period;
    int hold_left;
    seg_left      = 0;
    style         = 0;
    odds          = 4;
    period        = 3;
    hold_left     = 0;
    res_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        hold_left--;
        res_bus.ready = 1'b0;
      end else if (squeeze_req) begin
        squeeze_req   = 1'b0;
        hold_left     = SQUEEZE_CYCLES - 1;
        res_bus.ready = 1'b0;
      end else begin
        if (seg_left == 0) begin
          seg_left = $urandom_range(16, 200);
          style    = $urandom_range(0, 2);
          odds     = $urandom_range(1, 7);
          period   = $urandom_range(2, 6);
        end
        seg_left--;
        case (style)
          0: begin
            res_bus.ready = 1'b1;
          end
          1: begin
            res_bus.ready = ($urandom_range(0, 7) < odds);
          end
          default: begin
            res_bus.ready = ((seg_left % period) != 0);
          end
        endcase
      end
    end
  end

  initial begin : stimulus
    stim_row_t                     plan [$];
    logic [pcma_pkg::SAMPLE_W-1:0] smp;
    int                            c;
    int                            k;
    int                            phase;
    int                            n;

    rst                   = 1'b1;
    smp_bus.valid         = 1'b0;
    smp_bus.channel_tag   = '0;
    smp_bus.sample_value  = '0;
    cfg_bus.valid         = 1'b0;
    cfg_bus.high_res_mode = 1'b0;
    word_typed            = 1'b0;
    word_exp_val          = '0;
    word_exp_full         = 1'b0;
    burst_left            = 0;
    squeeze_req           = 1'b0;
    mismatches            = 0;

    // The predictor starts from the same empty state as the block after reset.
    for (c = 0; c < CHANNELS; c++) begin
      for (k = 0; k < WIN_LEN; k++) begin
        history[c][k] = '0;
      end
      chan_sum[c]   = '0;
      write_pos[c]  = '0;
      fill_level[c] = '0;
    end
    hi_res = 1'b0;

    // Directed table. The first word on an empty channel is the sample
    // itself. Channel 7 is filled with full-scale samples: the word that
    // completes the window still divides and reports not full, and the
    // next one takes the shifted path with the same value.
    plan.push_back('{ROW_SETUP, 1'b0, '0, '0, 0, 1'b0, '0, 1'b0});
    plan.push_back('{ROW_WORD, 1'b0, 4'd0, SAMPLE_TOP, 1, 1'b1, 13'd4095, 1'b0});
    plan.push_back('{ROW_WORD, 1'b0, 4'd15, 12'd0, 1, 1'b1, 13'd0, 1'b0});
    plan.push_back('{ROW_WORD, 1'b0, 4'd7, SAMPLE_TOP, 15, 1'b1, 13'd4095, 1'b0});
    plan.push_back('{ROW_WORD, 1'b0, 4'd7, SAMPLE_TOP, 1, 1'b1, 13'd4095, 1'b0});
    plan.push_back('{ROW_WORD, 1'b0, 4'd7, SAMPLE_TOP, 1, 1'b1, 13'd4095, 1'b1});
    plan.push_back('{ROW_WORD, 1'b0, 4'd7, 12'd0, 1, 1'b0, '0, 1'b0});
    plan.push_back('{ROW_WORD, 1'b0, 4'd1, 12'hAAA, 1, 1'b0, '0, 1'b0});
    plan.push_back('{ROW_WORD, 1'b0, 4'd1, 12'h555, 1, 1'b0, '0, 1'b0});
    // High-resolution mode on a full window gives the wider result.
    plan.push_back('{ROW_SETUP, 1'b1, '0, '0, 0, 1'b0, '0, 1'b0});
    plan.push_back('{ROW_WORD, 1'b0, 4'd7, SAMPLE_TOP, 1, 1'b0, '0, 1'b0});

    repeat (12) @(negedge clk);
    rst = 1'b0;

    foreach (plan[r]) begin
      if (plan[r].kind == ROW_SETUP) begin
        write_mode(plan[r].mode);
      end else begin
        repeat (plan[r].reps) begin
          send_word(plan[r].ch, plan[r].smp, plan[r].typed, plan[r].exp_val,
                    plan[r].exp_full);
        end
      end
    end

    // Random phases alternate the mode, starting with high resolution.
    // Samples lean toward zero, full scale and the ends of the range so that
    // sums reach their extremes; the rest are uniform.
    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      write_mode((phase % 2) == 0);
      for (n = 0; n < RANDOM_PER_PHASE; n++) begin
        if (phase == 0 && n == 24) begin
          squeeze_req = 1'b1;
        end
        case ($urandom_range(0, 7))
          0: smp = '0;
          1: smp = SAMPLE_TOP;
          2: smp = pcma_pkg::SAMPLE_W'($urandom_range(0, 15));
          3: smp = SAMPLE_TOP - pcma_pkg::SAMPLE_W'($urandom_range(0, 15));
          default: smp = pcma_pkg::SAMPLE_W'($urandom_range(0, SAMPLE_TOP));
        endcase
        send_word(pcma_pkg::TAG_W'($urandom_range(0, CHANNELS - 1)), smp, 1'b0, '0, 1'b0);
      end
    end
    smp_bus.valid = 1'b0;

    while (expected_averages.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatches == 0) begin
      $display("per_channel_moving_average_top_tb passed");
    end else begin
      $display("per_channel_moving_average_top_tb failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
src/pcma_pkg.sv
src/pcma_if.sv
src/pcma_divider.sv
src/pcma_history.sv
src/per_channel_moving_average_top.sv
sim/per_channel_moving_average_top_tb.sv
